// ===== sv/papm_pkg.sv =====
// Shared types and constants for the premultiplied ARGB pixel converter.
package papm_pkg;

	// Pixel mode codes held in the pixel_mode register.
	typedef enum logic [1:0] {
		MODE_OPAQUE = 2'd0,
		MODE_MASK   = 2'd1,
		MODE_PREMUL = 2'd2,
		MODE_RSVD   = 2'd3
	} pixel_mode_t;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PIXEL_MODE     = 2'd0;
	localparam logic [1:0] REG_SOURCE_IS_BGR  = 2'd1;
	localparam logic [1:0] REG_ALPHA_FIRST    = 2'd2;
	localparam logic [1:0] REG_MASK_MSB_FIRST = 2'd3;

	localparam int unsigned ChanW = 8;
	localparam logic [ChanW-1:0] OpaqueAlpha = 8'hff;

	// Stage-one control handed from the front end to the merging stage.
	typedef struct packed {
		pixel_mode_t mode;
		logic        alpha_first;
		logic        mask_set;
	} papm_ctrl_t;

endpackage

// ===== sv/papm_lane.sv =====
// One colour lane: registered 8x8 product, then rounding offset and divide by 255.
module papm_lane import papm_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [ChanW-1:0] color,
	input  logic [ChanW-1:0] alpha,
	input  logic [ChanW-1:0] alpha_s1,
	output logic [ChanW-1:0] quotient
);

	logic [2*ChanW-1:0] prod_s1;
	logic [ChanW-2:0]   half;
	logic [2*ChanW-1:0] diff;
	logic [2*ChanW:0]   sum;

	// Product of colour and alpha, captured with the rest of stage one.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= (2*ChanW)'(color) * (2*ChanW)'(alpha);
		end
	end

	// Subtract half the alpha; a negative numerator clamps to zero.
	// Division by 255 uses x/255 = (x + (x >> 8) + 1) >> 8 for x below 65535.
	always_comb begin
		half = alpha_s1[ChanW-1:1];
		diff = prod_s1 - (2*ChanW)'(half);
		sum  = (2*ChanW+1)'(diff) + (2*ChanW+1)'(diff[2*ChanW-1:ChanW])
			+ (2*ChanW+1)'(1);
		if (prod_s1 < (2*ChanW)'(half)) begin
			quotient = '0;
		end else begin
			quotient = sum[2*ChanW-1:ChanW];
		end
	end

endmodule

// ===== sv/papm_merge.sv =====
// Merging stage: picks lane results by mode, packs the word and holds the output request.
module papm_merge import papm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	output logic              advance,
	input  papm_ctrl_t        ctrl_s1,
	input  logic [ChanW-1:0]  red_s1,
	input  logic [ChanW-1:0]  green_s1,
	input  logic [ChanW-1:0]  blue_s1,
	input  logic [ChanW-1:0]  alpha_s1,
	input  logic [ChanW-1:0]  red_pm,
	input  logic [ChanW-1:0]  green_pm,
	input  logic [ChanW-1:0]  blue_pm,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ChanW-1:0]  out_alpha,
	output logic [ChanW-1:0]  out_red,
	output logic [ChanW-1:0]  out_green,
	output logic [ChanW-1:0]  out_blue,
	output logic [4*ChanW-1:0] packed_pixel
);

	logic              valid_s2;
	logic [ChanW-1:0]  a_sel, r_sel, g_sel, b_sel;
	logic [ChanW-1:0]  alpha_s2, red_s2, green_s2, blue_s2;
	logic [4*ChanW-1:0] packed_s2;
	logic [4*ChanW-1:0] packed_sel;

	// The output register takes a new request when empty or being drained.
	assign advance = !valid_s2 || out_ready;

	// Select channel values for the current mode.
	always_comb begin
		case (ctrl_s1.mode)
			MODE_MASK: begin
				if (ctrl_s1.mask_set) begin
					a_sel = OpaqueAlpha;
					r_sel = red_s1;
					g_sel = green_s1;
					b_sel = blue_s1;
				end else begin
					a_sel = '0;
					r_sel = '0;
					g_sel = '0;
					b_sel = '0;
				end
			end
			MODE_PREMUL: begin
				a_sel = alpha_s1;
				r_sel = red_pm;
				g_sel = green_pm;
				b_sel = blue_pm;
			end
			default: begin
				a_sel = OpaqueAlpha;
				r_sel = red_s1;
				g_sel = green_s1;
				b_sel = blue_s1;
			end
		endcase
		if (ctrl_s1.alpha_first) begin
			packed_sel = {a_sel, r_sel, g_sel, b_sel};
		end else begin
			packed_sel = {r_sel, g_sel, b_sel, a_sel};
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			alpha_s2  <= a_sel;
			red_s2    <= r_sel;
			green_s2  <= g_sel;
			blue_s2   <= b_sel;
			packed_s2 <= packed_sel;
		end
	end

	assign out_valid    = valid_s2;
	assign out_alpha    = alpha_s2;
	assign out_red      = red_s2;
	assign out_green    = green_s2;
	assign out_blue     = blue_s2;
	assign packed_pixel = packed_s2;

`ifndef NO_ASSERTIONS
	// The packed word always agrees with the separate channel outputs.
	a_packed_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (packed_pixel == {out_alpha, out_red, out_green, out_blue})
			|| (packed_pixel == {out_red, out_green, out_blue, out_alpha}))
		else $error("packed pixel disagrees with channel outputs");

	// A loaded premultiplied result never exceeds its alpha.
	a_premul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && ctrl_s1.mode == MODE_PREMUL |=>
			out_red <= out_alpha && out_green <= out_alpha && out_blue <= out_alpha)
		else $error("premultiplied channel exceeds alpha");

	// A mask pixel is either fully opaque or fully zero.
	a_mask_binary: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && ctrl_s1.mode == MODE_MASK |=>
			out_alpha == OpaqueAlpha
			|| (out_alpha == '0 && out_red == '0 && out_green == '0 && out_blue == '0))
		else $error("mask pixel is neither opaque nor clear");
`endif

endmodule

// ===== sv/pixel_to_premultiplied_argb_core.sv =====
// Top level of the pixel to premultiplied ARGB converter.
// Converts one pixel per clock, unless out_ready stalls it, into alpha, red, green,
// blue and a packed 32-bit word. Each accepted request is registered in turn: stage one
// holds the three per-channel 8x8 products, the output register holds the
// divided, selected and packed result. With out_ready held high a request is
// accepted every cycle; the output register and stage one together hold two
// requests under back pressure. Configuration registers are read live and must
// be written only while no request is in flight.
module pixel_to_premultiplied_argb_core import papm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ChanW-1:0]   source_byte_0,
	input  logic [ChanW-1:0]   source_byte_1,
	input  logic [ChanW-1:0]   source_byte_2,
	input  logic [ChanW-1:0]   alpha_level,
	input  logic [ChanW-1:0]   mask_byte,
	input  logic [2:0]         column_in_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ChanW-1:0]   out_alpha,
	output logic [ChanW-1:0]   out_red,
	output logic [ChanW-1:0]   out_green,
	output logic [ChanW-1:0]   out_blue,
	output logic [4*ChanW-1:0] packed_pixel
);

	pixel_mode_t      pixel_mode_q;
	logic             source_is_bgr_q;
	logic             alpha_first_q;
	logic             mask_msb_first_q;

	logic             valid_s1;
	logic             advance;
	logic [ChanW-1:0] red_in, blue_in;
	logic [2:0]       mask_pos;
	papm_ctrl_t       ctrl_in, ctrl_s1;
	logic [ChanW-1:0] red_s1, green_s1, blue_s1, alpha_s1;
	logic [ChanW-1:0] red_pm, green_pm, blue_pm;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q     <= MODE_OPAQUE;
			source_is_bgr_q  <= 1'b0;
			alpha_first_q    <= 1'b0;
			mask_msb_first_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PIXEL_MODE:     pixel_mode_q     <= pixel_mode_t'(cfg_data);
				REG_SOURCE_IS_BGR:  source_is_bgr_q  <= cfg_data[0];
				REG_ALPHA_FIRST:    alpha_first_q    <= cfg_data[0];
				REG_MASK_MSB_FIRST: mask_msb_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage one loads when empty or when the output stage moves on.
	assign in_ready = !valid_s1 || advance;

	// Channel order and mask bit selection.
	always_comb begin
		red_in   = source_is_bgr_q ? source_byte_2 : source_byte_0;
		blue_in  = source_is_bgr_q ? source_byte_0 : source_byte_2;
		mask_pos = mask_msb_first_q ? ~column_in_byte : column_in_byte;
		ctrl_in.mode        = pixel_mode_q;
		ctrl_in.alpha_first = alpha_first_q;
		ctrl_in.mask_set    = mask_byte[mask_pos];
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			ctrl_s1  <= ctrl_in;
			red_s1   <= red_in;
			green_s1 <= source_byte_1;
			blue_s1  <= blue_in;
			alpha_s1 <= alpha_level;
		end
	end

	// Three premultiply lanes, one per colour channel.
	papm_lane u_lane_red (
		.clk      (clk),
		.load     (in_ready),
		.color    (red_in),
		.alpha    (alpha_level),
		.alpha_s1 (alpha_s1),
		.quotient (red_pm)
	);

	papm_lane u_lane_green (
		.clk      (clk),
		.load     (in_ready),
		.color    (source_byte_1),
		.alpha    (alpha_level),
		.alpha_s1 (alpha_s1),
		.quotient (green_pm)
	);

	papm_lane u_lane_blue (
		.clk      (clk),
		.load     (in_ready),
		.color    (blue_in),
		.alpha    (alpha_level),
		.alpha_s1 (alpha_s1),
		.quotient (blue_pm)
	);

	papm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.advance      (advance),
		.ctrl_s1      (ctrl_s1),
		.red_s1       (red_s1),
		.green_s1     (green_s1),
		.blue_s1      (blue_s1),
		.alpha_s1     (alpha_s1),
		.red_pm       (red_pm),
		.green_pm     (green_pm),
		.blue_pm      (blue_pm),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_alpha    (out_alpha),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.packed_pixel (packed_pixel)
	);

`ifndef NO_ASSERTIONS
	// A request held in stage one is not dropped while the output stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |=> valid_s1)
		else $error("stage one request lost under stall");

	// An accepted request always reaches stage one.
	a_s1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted request missing from stage one");

	// Input stalls only when both stages hold requests.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== tb/pixel_to_premultiplied_argb_core_test.sv =====
// Self-checking testbench for the pixel to premultiplied ARGB converter.
module pixel_to_premultiplied_argb_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import papm_pkg::*;

	localparam int unsigned CycleLimit    = 600000;
	localparam int unsigned PipeDrain     = 4;
	localparam int unsigned HoldOffCycles = 160;
	localparam int unsigned RandomPhases  = 10;
	localparam int unsigned PhaseItems    = 95;

	// One source pixel as it is offered on the input channel.
	typedef struct packed {
		logic [ChanW-1:0] byte0;
		logic [ChanW-1:0] byte1;
		logic [ChanW-1:0] byte2;
		logic [ChanW-1:0] alpha;
		logic [ChanW-1:0] mask;
		logic [2:0]       column;
	} source_pixel_t;

	// One converted pixel as it leaves the output channel.
	typedef struct packed {
		logic [ChanW-1:0]   alpha;
		logic [ChanW-1:0]   red;
		logic [ChanW-1:0]   green;
		logic [ChanW-1:0]   blue;
		logic [4*ChanW-1:0] word;
	} argb_pixel_t;

	// Mirrors the converter's registers and keeps the converted pixels still owed.
	class argb_tracker;
		pixel_mode_t mode = MODE_OPAQUE;
		bit bgr = 1'b0;
		bit alpha_first = 1'b0;
		bit msb_first = 1'b1;
		argb_pixel_t pending_pixels[$];
		int unsigned failures = 0;
		int unsigned checked = 0;
		int unsigned settings = 0;
		int unsigned mode_hits[4] = '{0, 0, 0, 0};

		function void write_reg(logic [1:0] index, logic [1:0] data);
			case (index)
				REG_PIXEL_MODE: mode = pixel_mode_t'(data);
				REG_SOURCE_IS_BGR: bgr = data[0];
				REG_ALPHA_FIRST: alpha_first = data[0];
				REG_MASK_MSB_FIRST: msb_first = data[0];
				default: ;
			endcase
		endfunction

		// Scales one channel by alpha with the half-alpha rounding bias, clamped at zero.
		function logic [ChanW-1:0] scale_channel(logic [ChanW-1:0] c, logic [ChanW-1:0] a);
			logic [15:0] prod;
			logic [15:0] half;
			prod = {8'd0, c} * {8'd0, a};
			half = {9'd0, a[ChanW-1:1]};
			if (prod < half)
				return '0;
			return 8'((prod - half) / 16'd255);
		endfunction

		function argb_pixel_t convert_pixel(source_pixel_t px);
			argb_pixel_t res;
			logic [2:0] pos;
			res.red = bgr ? px.byte2 : px.byte0;
			res.blue = bgr ? px.byte0 : px.byte2;
			res.green = px.byte1;
			case (mode)
				MODE_MASK: begin
					pos = msb_first ? 3'd7 - px.column : px.column;
					if (px.mask[pos]) begin
						res.alpha = OpaqueAlpha;
					end else begin
						res.alpha = '0;
						res.red = '0;
						res.green = '0;
						res.blue = '0;
					end
				end
				MODE_PREMUL: begin
					res.alpha = px.alpha;
					res.red = scale_channel(res.red, px.alpha);
					res.green = scale_channel(res.green, px.alpha);
					res.blue = scale_channel(res.blue, px.alpha);
				end
				default: res.alpha = OpaqueAlpha;
			endcase
			res.word = alpha_first ? {res.alpha, res.red, res.green, res.blue}
				: {res.red, res.green, res.blue, res.alpha};
			return res;
		endfunction

		function void note_request(source_pixel_t px);
			pending_pixels.push_back(convert_pixel(px));
			mode_hits[mode]++;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				failures++;
				$error("%s mismatch: expected %0h, got %0h", field, want, got);
			end
		endfunction

		function void check_result(argb_pixel_t got);
			argb_pixel_t want;
			if (pending_pixels.size() == 0) begin
				failures++;
				$error("converted pixel %08h arrived with no request pending", got.word);
				return;
			end
			want = pending_pixels.pop_front();
			checked++;
			compare("out_alpha", 32'(want.alpha), 32'(got.alpha));
			compare("out_red", 32'(want.red), 32'(got.red));
			compare("out_green", 32'(want.green), 32'(got.green));
			compare("out_blue", 32'(want.blue), 32'(got.blue));
			compare("packed_pixel", want.word, got.word);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [1:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [ChanW-1:0]   source_byte_0 = '0;
	logic [ChanW-1:0]   source_byte_1 = '0;
	logic [ChanW-1:0]   source_byte_2 = '0;
	logic [ChanW-1:0]   alpha_level = '0;
	logic [ChanW-1:0]   mask_byte = '0;
	logic [2:0]         column_in_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ChanW-1:0]   out_alpha;
	logic [ChanW-1:0]   out_red;
	logic [ChanW-1:0]   out_green;
	logic [ChanW-1:0]   out_blue;
	logic [4*ChanW-1:0] packed_pixel;

	argb_tracker tracker = new();
	int unsigned cycle_count = 0;
	bit tx_steady = 1'b1;
	bit rx_steady = 1'b1;
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned rx_gap_left = 0;

	pixel_to_premultiplied_argb_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.source_byte_0(source_byte_0),
		.source_byte_1(source_byte_1),
		.source_byte_2(source_byte_2),
		.alpha_level(alpha_level),
		.mask_byte(mask_byte),
		.column_in_byte(column_in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_alpha(out_alpha),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.packed_pixel(packed_pixel)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit in case a handshake never completes.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("pixel_to_premultiplied_argb_core regression: fail");
			$finish;
		end
	end

	// Record accepted requests and check delivered pixels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_request({source_byte_0, source_byte_1, source_byte_2,
					alpha_level, mask_byte, column_in_byte});
			if (out_valid && out_ready)
				tracker.check_result({out_alpha, out_red, out_green, out_blue, packed_pixel});
		end
	end

	// Returns a gap length: mostly short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, steady stretches, and long hold-offs on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (hold_served != hold_asks) begin
			hold_served++;
			hold_left = HoldOffCycles - 1;
			out_ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else if (rx_gap_left > 0) begin
			rx_gap_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = 1'b1;
			if (!rx_steady && $urandom_range(0, 3) == 0)
				rx_gap_left = pick_gap();
		end
	end

	// Offers one pixel and holds it until the converter takes it.
	task automatic offer_pixel(input source_pixel_t px);
		in_valid = 1'b1;
		source_byte_0 = px.byte0;
		source_byte_1 = px.byte1;
		source_byte_2 = px.byte2;
		alpha_level = px.alpha;
		mask_byte = px.mask;
		column_in_byte = px.column;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (!tx_steady && $urandom_range(0, 2) == 0) begin
			in_valid = 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
	endtask

	// Drops valid and waits until every owed pixel has come out.
	task automatic drain_pipeline();
		in_valid = 1'b0;
		while (tracker.pending_pixels.size() != 0)
			@(negedge clk);
		repeat (PipeDrain) @(negedge clk);
	endtask

	// Writes all four registers back to back; the converter must be idle.
	task automatic apply_settings(input logic [1:0] mode, input logic [1:0] bgr,
			input logic [1:0] alpha_first, input logic [1:0] msb_first);
		logic [1:0] values[4];
		values[REG_PIXEL_MODE] = mode;
		values[REG_SOURCE_IS_BGR] = bgr;
		values[REG_ALPHA_FIRST] = alpha_first;
		values[REG_MASK_MSB_FIRST] = msb_first;
		for (int i = 0; i < 4; i++) begin
			cfg_we = 1'b1;
			cfg_index = 2'(i);
			cfg_data = values[i];
			tracker.write_reg(2'(i), values[i]);
			@(negedge clk);
		end
		cfg_we = 1'b0;
		tracker.settings++;
	endtask

	// Channel level biased toward the ends of the range.
	function automatic logic [ChanW-1:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'(($urandom_range(0, 1) == 0) ? 1 : 2);
			3: return 8'hfe;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		source_pixel_t px;
		pixel_mode_t mode;

		// Hold reset, then release it at a falling edge.
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		rx_steady = 1'b0;

		// Reset settings: opaque, RGB order, alpha last; alpha and mask are ignored.
		offer_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0});
		offer_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7});
		offer_pixel('{8'h12, 8'h34, 8'h56, 8'h9a, 8'h5a, 3'd3});
		drain_pipeline();

		// Reserved mode behaves as opaque; BGR order with alpha first.
		apply_settings(MODE_RSVD, 2'd1, 2'd1, 2'd0);
		offer_pixel('{8'h01, 8'h80, 8'hfe, 8'h00, 8'h00, 3'd5});
		offer_pixel('{8'hff, 8'h00, 8'h00, 8'h40, 8'hff, 3'd2});
		drain_pipeline();

		// Mask mode, MSB first: set bits give opaque pixels, clear bits give zeros.
		apply_settings(MODE_MASK, 2'd0, 2'd0, 2'd1);
		offer_pixel('{8'hff, 8'hff, 8'hff, 8'h00, 8'h80, 3'd0});
		offer_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 8'h80, 3'd7});
		offer_pixel('{8'h11, 8'h22, 8'h33, 8'h00, 8'h01, 3'd7});
		offer_pixel('{8'h44, 8'h55, 8'h66, 8'h00, 8'hfe, 3'd7});
		drain_pipeline();

		// Mask mode, LSB first.
		apply_settings(MODE_MASK, 2'd1, 2'd1, 2'd0);
		offer_pixel('{8'h77, 8'h88, 8'h99, 8'h00, 8'h01, 3'd0});
		offer_pixel('{8'haa, 8'hbb, 8'hcc, 8'h00, 8'h80, 3'd7});
		offer_pixel('{8'hdd, 8'hee, 8'hff, 8'h00, 8'hfe, 3'd0});
		drain_pipeline();

		// Premultiply: full scale gives 254, zero colour clamps, zero and tiny alpha.
		apply_settings(MODE_PREMUL, 2'd0, 2'd1, 2'd1);
		offer_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 3'd0});
		offer_pixel('{8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 3'd0});
		offer_pixel('{8'hff, 8'h80, 8'h01, 8'h00, 8'h00, 3'd0});
		offer_pixel('{8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 3'd0});
		offer_pixel('{8'h01, 8'h02, 8'h03, 8'h02, 8'hff, 3'd7});
		offer_pixel('{8'hc8, 8'h64, 8'h32, 8'h80, 8'h00, 3'd0});
		drain_pipeline();

		// Random phases, each with fresh register settings and handshake style.
		for (int p = 0; p < RandomPhases; p++) begin
			mode = pixel_mode_t'(p % 4);
			if (p >= 4 && $urandom_range(0, 1) == 0)
				mode = ($urandom_range(0, 1) == 0) ? MODE_MASK : MODE_PREMUL;
			apply_settings(mode, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)));
			tx_steady = (p % 3 == 0);
			rx_steady = (p == 1 || p == 7);
			// A long receiver hold-off fills the converter while requests keep coming.
			if (p == 2 || p == 6) begin
				tx_steady = 1'b1;
				hold_asks++;
			end
			for (int n = 0; n < PhaseItems; n++) begin
				px.byte0 = pick_level();
				px.byte1 = pick_level();
				px.byte2 = pick_level();
				px.alpha = pick_level();
				px.mask = 8'($urandom_range(0, 255));
				px.column = 3'($urandom_range(0, 7));
				offer_pixel(px);
			end
			drain_pipeline();
		end

		$display("Checked %0d pixels over %0d register settings with %0d receiver hold-offs.",
			tracker.checked, tracker.settings, hold_asks);
		$display("Pixels per mode: opaque %0d, mask %0d, premultiply %0d, reserved %0d.",
			tracker.mode_hits[MODE_OPAQUE], tracker.mode_hits[MODE_MASK],
			tracker.mode_hits[MODE_PREMUL], tracker.mode_hits[MODE_RSVD]);
		if (tracker.failures == 0 && tracker.pending_pixels.size() == 0)
			$display("pixel_to_premultiplied_argb_core regression: pass");
		else
			$display("pixel_to_premultiplied_argb_core regression: fail");
		$finish;
	end

endmodule
